/* design/gnms_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the greedy IoU box suppression block.
// Used by the channel interfaces, the input queue and the suppression engine.
package gnms_pkg;

  localparam int MaxBoxes = 64;
  localparam int IdxW     = $clog2(MaxBoxes);
  localparam int CntW     = $clog2(MaxBoxes + 1);
  localparam int CoordW   = 16;
  localparam int ScoreW   = 16;
  localparam int AreaW    = 2 * CoordW;
  localparam int UniW     = AreaW + 1;
  localparam int Q16Shift = 16;
  localparam int ProdW    = UniW + ScoreW;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegScoreFloor   = 1'b0,
    RegOverlapLimit = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [ScoreW-1:0] score;
  } box_t;

  typedef struct packed {
    box_t box;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [AreaW-1:0] area;
  } kept_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_RANK_RD,
    S_RANK_CMP,
    S_WALK_RD,
    S_WALK_IDX,
    S_WALK_BOX,
    S_WALK_AREA,
    S_CMP_RD,
    S_CMP_BOX,
    S_CMP_SPAN,
    S_CMP_MUL,
    S_CMP_UNI,
    S_CMP_TEST,
    S_KEEP,
    S_NEXT,
    S_EMIT_START,
    S_EMIT_RD,
    S_EMIT_BOX,
    S_EMIT_OUT,
    S_EMIT_NONE
  } state_t;

  // Length of an interval, zero when it is empty or inverted.
  function automatic logic [CoordW-1:0] span(input logic [CoordW-1:0] lo,
                                             input logic [CoordW-1:0] hi);
    span = (hi > lo) ? (hi - lo) : '0;
  endfunction

endpackage

/* design/gnms_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for box items and result items.
// Depends on gnms_pkg for field widths.
interface gnms_box_if;
  logic                         valid;
  logic                         ready;
  logic [gnms_pkg::CoordW-1:0]  left_edge;
  logic [gnms_pkg::CoordW-1:0]  top_edge;
  logic [gnms_pkg::CoordW-1:0]  right_edge;
  logic [gnms_pkg::CoordW-1:0]  bottom_edge;
  logic [gnms_pkg::ScoreW-1:0]  confidence;
  logic                         final_box;
  modport source (output valid, left_edge, top_edge, right_edge, bottom_edge,
                  confidence, final_box, input ready);
  modport sink (input valid, left_edge, top_edge, right_edge, bottom_edge,
                confidence, final_box, output ready);
endinterface

interface gnms_result_if;
  logic                         valid;
  logic                         ready;
  logic [gnms_pkg::IdxW-1:0]    source_index;
  logic [gnms_pkg::CoordW-1:0]  out_left;
  logic [gnms_pkg::CoordW-1:0]  out_top;
  logic [gnms_pkg::CoordW-1:0]  out_right;
  logic [gnms_pkg::CoordW-1:0]  out_bottom;
  logic [gnms_pkg::ScoreW-1:0]  out_confidence;
  logic                         final_result;
  logic                         none_kept;
  logic                         dropped_flag;
  modport source (output valid, source_index, out_left, out_top, out_right,
                  out_bottom, out_confidence, final_result, none_kept,
                  dropped_flag, input ready);
  modport sink (input valid, source_index, out_left, out_top, out_right,
                out_bottom, out_confidence, final_result, none_kept,
                dropped_flag, output ready);
endinterface

/* design/greedy_iou_box_suppression.sv */
`timescale 1ns / 1ps
// Top level of the greedy IoU box suppression block.
// Depends on gnms_pkg, gnms_ifs, gnms_queue and gnms_engine.
//
// Boxes are taken one per cycle while the engine loads, through a four-entry queue
// into a 64-entry box store with two read ports. After the item marked final, the
// engine ranks the set by pairwise score compares, then walks the ranking, testing
// each ranked box against the boxes kept so far. Results then leave one at a time
// through an output register. While a set is ranked, suppressed and emitted the
// engine takes no new box; up to four boxes of the next set wait in the queue.
module greedy_iou_box_suppression (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gnms_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gnms_pkg::CfgDataW-1:0] cfg_data,
  gnms_box_if.sink                      box_in,
  gnms_result_if.source                 res_out
);

  gnms_pkg::in_item_t in_item;
  gnms_pkg::in_item_t q_item;
  logic               q_valid;
  logic               q_ready;

  assign in_item.box.left   = box_in.left_edge;
  assign in_item.box.top    = box_in.top_edge;
  assign in_item.box.right  = box_in.right_edge;
  assign in_item.box.bottom = box_in.bottom_edge;
  assign in_item.box.score  = box_in.confidence;
  assign in_item.last       = box_in.final_box;

  gnms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (box_in.valid),
    .in_ready  (box_in.ready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  gnms_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res       (res_out)
  );

endmodule

/* design/gnms_queue.sv */
`timescale 1ns / 1ps
// Small FIFO that takes box items from the input channel ahead of the engine.
// Depends on gnms_pkg for the item type and depth.
module gnms_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gnms_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gnms_pkg::in_item_t out_item
);

  gnms_pkg::in_item_t              slots [gnms_pkg::QDepth];
  logic [gnms_pkg::QPtrW-1:0]      wr_ptr;
  logic [gnms_pkg::QPtrW-1:0]      rd_ptr;
  logic [gnms_pkg::QPtrW:0]        fill;
  logic                            push;
  logic                            pop;

  assign in_ready  = (fill != (gnms_pkg::QPtrW+1)'(gnms_pkg::QDepth));
  assign out_valid = (fill != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* design/gnms_engine.sv */
`timescale 1ns / 1ps
// Box store, score ranking, greedy IoU suppression and result output.
// Depends on gnms_pkg and the result channel interface.
module gnms_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gnms_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gnms_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  gnms_pkg::in_item_t            q_item,
  gnms_result_if.source                 res
);

  gnms_pkg::state_t state;
  gnms_pkg::state_t state_next;

  logic [gnms_pkg::ScoreW-1:0] score_floor;
  logic [gnms_pkg::ScoreW-1:0] overlap_limit;

  logic [gnms_pkg::CntW-1:0]   loaded_count;
  logic                        overflow_seen;
  logic [gnms_pkg::CntW-1:0]   kept_count;

  gnms_pkg::box_t              box_mem [gnms_pkg::MaxBoxes];
  gnms_pkg::box_t              box_a_q;
  gnms_pkg::box_t              box_b_q;
  logic [gnms_pkg::IdxW-1:0]   rank_mem [gnms_pkg::MaxBoxes];
  logic [gnms_pkg::IdxW-1:0]   rank_q;
  gnms_pkg::kept_t             kept_mem [gnms_pkg::MaxBoxes];
  gnms_pkg::kept_t             kept_q;

  logic [gnms_pkg::IdxW-1:0]   ri;
  logic [gnms_pkg::IdxW-1:0]   rj;
  logic [gnms_pkg::IdxW-1:0]   rank_cnt;
  logic [gnms_pkg::IdxW-1:0]   rpos;
  logic [gnms_pkg::IdxW-1:0]   kt;
  logic [gnms_pkg::IdxW-1:0]   cur_idx;

  logic [gnms_pkg::CoordW-1:0] cur_sw;
  logic [gnms_pkg::CoordW-1:0] cur_sh;
  logic [gnms_pkg::AreaW-1:0]  cur_area;
  logic [gnms_pkg::CoordW-1:0] int_w;
  logic [gnms_pkg::CoordW-1:0] int_h;
  logic [gnms_pkg::AreaW-1:0]  inter;
  logic [gnms_pkg::UniW-1:0]   uni;

  logic                        out_valid_r;
  logic [gnms_pkg::IdxW-1:0]   out_idx_r;
  gnms_pkg::box_t              out_box_r;
  logic                        out_final_r;
  logic                        out_none_r;
  logic                        out_drop_r;

  logic [gnms_pkg::IdxW-1:0]   addr_a;
  logic [gnms_pkg::IdxW-1:0]   addr_b;
  logic                        box_we;
  logic                        rank_we;
  logic [gnms_pkg::IdxW-1:0]   rank_waddr;
  logic                        kept_we;
  logic                        out_load;
  logic                        set_done;

  logic [gnms_pkg::CntW-1:0]   last_box;
  logic [gnms_pkg::CntW-1:0]   last_kept;
  logic                        ri_last;
  logic                        rj_last;
  logic                        rpos_last;
  logic                        kt_last;
  logic                        beats;
  logic                        below_floor;
  logic                        suppress;
  logic                        out_free;
  logic                        accept;
  logic [gnms_pkg::ProdW-1:0]  lhs;
  logic [gnms_pkg::ProdW-1:0]  rhs;
  logic [gnms_pkg::CoordW-1:0] il;
  logic [gnms_pkg::CoordW-1:0] ir;
  logic [gnms_pkg::CoordW-1:0] it;
  logic [gnms_pkg::CoordW-1:0] ib;

  assign last_box    = loaded_count - 1'b1;
  assign last_kept   = kept_count - 1'b1;
  assign ri_last     = (gnms_pkg::CntW'(ri) == last_box);
  assign rj_last     = (gnms_pkg::CntW'(rj) == last_box);
  assign rpos_last   = (gnms_pkg::CntW'(rpos) == last_box);
  assign kt_last     = (gnms_pkg::CntW'(kt) == last_kept);
  assign accept      = q_valid && q_ready;
  assign out_free    = !out_valid_r || res.ready;

  // Lower arrival index wins a tie in score.
  assign beats       = (box_b_q.score > box_a_q.score) ||
                       ((box_b_q.score == box_a_q.score) && (rj < ri));
  assign below_floor = (box_a_q.score < score_floor);

  assign il = (box_a_q.left > box_b_q.left) ? box_a_q.left : box_b_q.left;
  assign ir = (box_a_q.right < box_b_q.right) ? box_a_q.right : box_b_q.right;
  assign it = (box_a_q.top > box_b_q.top) ? box_a_q.top : box_b_q.top;
  assign ib = (box_a_q.bottom < box_b_q.bottom) ? box_a_q.bottom : box_b_q.bottom;

  // IoU above the limit, tested without division; an empty union never suppresses.
  assign lhs      = gnms_pkg::ProdW'({inter, {gnms_pkg::Q16Shift{1'b0}}});
  assign rhs      = gnms_pkg::ProdW'(overlap_limit) * gnms_pkg::ProdW'(uni);
  assign suppress = (uni != '0) && (lhs > rhs);

  always_comb begin
    state_next = state;
    unique case (state)
      gnms_pkg::S_LOAD: begin
        if (accept && q_item.last) begin
          state_next = gnms_pkg::S_RANK_RD;
        end
      end
      gnms_pkg::S_RANK_RD:  state_next = gnms_pkg::S_RANK_CMP;
      gnms_pkg::S_RANK_CMP: begin
        state_next = (rj_last && ri_last) ? gnms_pkg::S_WALK_RD : gnms_pkg::S_RANK_RD;
      end
      gnms_pkg::S_WALK_RD:  state_next = gnms_pkg::S_WALK_IDX;
      gnms_pkg::S_WALK_IDX: state_next = gnms_pkg::S_WALK_BOX;
      gnms_pkg::S_WALK_BOX: begin
        state_next = below_floor ? gnms_pkg::S_EMIT_START : gnms_pkg::S_WALK_AREA;
      end
      gnms_pkg::S_WALK_AREA: begin
        state_next = (kept_count == '0) ? gnms_pkg::S_KEEP : gnms_pkg::S_CMP_RD;
      end
      gnms_pkg::S_CMP_RD:   state_next = gnms_pkg::S_CMP_BOX;
      gnms_pkg::S_CMP_BOX:  state_next = gnms_pkg::S_CMP_SPAN;
      gnms_pkg::S_CMP_SPAN: state_next = gnms_pkg::S_CMP_MUL;
      gnms_pkg::S_CMP_MUL:  state_next = gnms_pkg::S_CMP_UNI;
      gnms_pkg::S_CMP_UNI:  state_next = gnms_pkg::S_CMP_TEST;
      gnms_pkg::S_CMP_TEST: begin
        if (suppress) begin
          state_next = gnms_pkg::S_NEXT;
        end else if (kt_last) begin
          state_next = gnms_pkg::S_KEEP;
        end else begin
          state_next = gnms_pkg::S_CMP_RD;
        end
      end
      gnms_pkg::S_KEEP: state_next = gnms_pkg::S_NEXT;
      gnms_pkg::S_NEXT: begin
        state_next = rpos_last ? gnms_pkg::S_EMIT_START : gnms_pkg::S_WALK_RD;
      end
      gnms_pkg::S_EMIT_START: begin
        state_next = (kept_count == '0) ? gnms_pkg::S_EMIT_NONE : gnms_pkg::S_EMIT_RD;
      end
      gnms_pkg::S_EMIT_RD:  state_next = gnms_pkg::S_EMIT_BOX;
      gnms_pkg::S_EMIT_BOX: state_next = gnms_pkg::S_EMIT_OUT;
      gnms_pkg::S_EMIT_OUT: begin
        if (out_free) begin
          state_next = kt_last ? gnms_pkg::S_LOAD : gnms_pkg::S_EMIT_RD;
        end
      end
      gnms_pkg::S_EMIT_NONE: begin
        if (out_free) begin
          state_next = gnms_pkg::S_LOAD;
        end
      end
      default: state_next = gnms_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    q_ready    = (state == gnms_pkg::S_LOAD);
    box_we     = (state == gnms_pkg::S_LOAD) && q_valid &&
                 (loaded_count != gnms_pkg::CntW'(gnms_pkg::MaxBoxes));
    rank_we    = (state == gnms_pkg::S_RANK_CMP) && rj_last;
    rank_waddr = rank_cnt + gnms_pkg::IdxW'(beats);
    kept_we    = (state == gnms_pkg::S_KEEP);
    out_load   = ((state == gnms_pkg::S_EMIT_OUT) || (state == gnms_pkg::S_EMIT_NONE)) &&
                 out_free;
    set_done   = out_load && ((state == gnms_pkg::S_EMIT_NONE) || kt_last);
    unique case (state) inside
      gnms_pkg::S_RANK_RD, gnms_pkg::S_RANK_CMP: begin
        addr_a = ri;
        addr_b = rj;
      end
      gnms_pkg::S_WALK_IDX: begin
        addr_a = rank_q;
        addr_b = kept_q.idx;
      end
      gnms_pkg::S_EMIT_BOX: begin
        addr_a = kept_q.idx;
        addr_b = kept_q.idx;
      end
      default: begin
        addr_a = cur_idx;
        addr_b = kept_q.idx;
      end
    endcase
  end

  // Memories: box store with two read ports, ranking and kept list.
  always_ff @(posedge clk) begin
    if (box_we) begin
      box_mem[loaded_count[gnms_pkg::IdxW-1:0]] <= q_item.box;
    end
    box_a_q <= box_mem[addr_a];
    box_b_q <= box_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= ri;
    end
    rank_q <= rank_mem[rpos];
  end

  always_ff @(posedge clk) begin
    if (kept_we) begin
      kept_mem[kept_count[gnms_pkg::IdxW-1:0]] <= '{idx: cur_idx, area: cur_area};
    end
    kept_q <= kept_mem[kt];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      gnms_pkg::S_WALK_IDX: cur_idx <= rank_q;
      gnms_pkg::S_EMIT_BOX: cur_idx <= kept_q.idx;
      default: cur_idx <= cur_idx;
    endcase
    if (state == gnms_pkg::S_WALK_BOX) begin
      cur_sw <= gnms_pkg::span(box_a_q.left, box_a_q.right);
      cur_sh <= gnms_pkg::span(box_a_q.top, box_a_q.bottom);
    end
    if (state == gnms_pkg::S_WALK_AREA) begin
      cur_area <= gnms_pkg::AreaW'(cur_sw) * gnms_pkg::AreaW'(cur_sh);
    end
    if (state == gnms_pkg::S_CMP_SPAN) begin
      int_w <= gnms_pkg::span(il, ir);
      int_h <= gnms_pkg::span(it, ib);
    end
    if (state == gnms_pkg::S_CMP_MUL) begin
      inter <= gnms_pkg::AreaW'(int_w) * gnms_pkg::AreaW'(int_h);
    end
    if (state == gnms_pkg::S_CMP_UNI) begin
      uni <= gnms_pkg::UniW'(cur_area) + gnms_pkg::UniW'(kept_q.area) -
             gnms_pkg::UniW'(inter);
    end
    if (out_load) begin
      if (state == gnms_pkg::S_EMIT_NONE) begin
        out_idx_r   <= '0;
        out_box_r   <= '0;
        out_final_r <= 1'b1;
        out_none_r  <= 1'b1;
      end else begin
        out_idx_r   <= cur_idx;
        out_box_r   <= box_a_q;
        out_final_r <= kt_last;
        out_none_r  <= 1'b0;
      end
      out_drop_r <= overflow_seen;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gnms_pkg::S_LOAD;
      score_floor   <= '0;
      overlap_limit <= gnms_pkg::ScoreW'(19661);
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
      kept_count    <= '0;
      ri            <= '0;
      rj            <= '0;
      rank_cnt      <= '0;
      rpos          <= '0;
      kt            <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          gnms_pkg::RegScoreFloor:   score_floor   <= cfg_data;
          gnms_pkg::RegOverlapLimit: overlap_limit <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (box_we) begin
          loaded_count <= loaded_count + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
        ri       <= '0;
        rj       <= '0;
        rank_cnt <= '0;
      end
      if (state == gnms_pkg::S_RANK_CMP) begin
        if (rj_last) begin
          rj       <= '0;
          rank_cnt <= '0;
          ri       <= ri + 1'b1;
          rpos     <= '0;
        end else begin
          rj       <= rj + 1'b1;
          rank_cnt <= rank_waddr;
        end
      end
      if (state == gnms_pkg::S_WALK_AREA) begin
        kt <= '0;
      end
      if ((state == gnms_pkg::S_CMP_TEST) && !suppress && !kt_last) begin
        kt <= kt + 1'b1;
      end
      if (kept_we) begin
        kept_count <= kept_count + 1'b1;
      end
      if ((state == gnms_pkg::S_NEXT) && !rpos_last) begin
        rpos <= rpos + 1'b1;
      end
      if (state == gnms_pkg::S_EMIT_START) begin
        kt <= '0;
      end
      if ((state == gnms_pkg::S_EMIT_OUT) && out_load && !kt_last) begin
        kt <= kt + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (set_done) begin
        loaded_count  <= '0;
        overflow_seen <= 1'b0;
        kept_count    <= '0;
      end
    end
  end

  assign res.valid          = out_valid_r;
  assign res.source_index   = out_idx_r;
  assign res.out_left       = out_box_r.left;
  assign res.out_top        = out_box_r.top;
  assign res.out_right      = out_box_r.right;
  assign res.out_bottom     = out_box_r.bottom;
  assign res.out_confidence = out_box_r.score;
  assign res.final_result   = out_final_r;
  assign res.none_kept      = out_none_r;
  assign res.dropped_flag   = out_drop_r;

`ifndef SYNTHESIS
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= loaded_count)
    else $error("kept list longer than the stored set");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_r) |-> ($past(state == gnms_pkg::S_EMIT_OUT) ||
                            $past(state == gnms_pkg::S_EMIT_NONE)))
    else $error("result raised outside the output states");

  a_overflow_set: assert property (@(posedge clk) disable iff (rst)
    (accept && (loaded_count == gnms_pkg::CntW'(gnms_pkg::MaxBoxes))) |=> overflow_seen)
    else $error("dropped box did not set the overflow flag");

  a_rank_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == gnms_pkg::S_RANK_RD) |-> (loaded_count != '0))
    else $error("ranking started on an empty set");
`endif

endmodule
